>>> hw/rtl/pidab_pkg.sv
// Shared constants, command/status types and codes for the blended PID unit.
package pidab_pkg;

    // Sample and gain formats
    localparam int DATA_W    = 32;   // Q16.16 samples
    localparam int GAIN_W    = 16;   // Q4.12 gains
    localparam int BLEND_W   = 13;   // Q1.12 blend weight, 4096 = 1.0
    localparam int BLEND_ONE = 4096;
    localparam int FRAC_W    = 12;   // gain fraction bits dropped after each product sum
    localparam int INTEG_W   = 48;   // Q32.16 integral
    localparam int FUNC_W    = 2;

    // Shared multiplier and accumulators
    localparam int MUL_A_W     = 17;
    localparam int MUL_B_W     = 34;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int ACC_W       = 66;
    localparam int PID_W       = 52;
    localparam int INTEG_SPLIT = 24;   // integral split into low/high halves
    localparam int PID_SPLIT   = 26;   // PID term split into low/high halves

    // Mean divider: quotient bits resolved per cycle
    localparam int DIV_STEPS = 8;

    localparam int WINDOW_LEN_DEF = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_W;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = 2'd3;

    // Request kinds
    localparam logic [FUNC_W-1:0] FUNC_STEP    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PRELOAD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

    // Multiplier operations
    typedef enum logic [2:0] {
        OP_KP_ERR,
        OP_KD_DIFF,
        OP_KI_LO,
        OP_KI_HI,
        OP_PID_LO,
        OP_PID_HI,
        OP_FB
    } op_t;

    typedef struct packed {
        logic step_load;
        logic preload;
        logic clear;
        logic fb_start;
        logic mul_en;
        op_t  op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic fb_ready;
        logic out_full;
    } sts_t;

endpackage

>>> hw/rtl/pid_with_averaged_feedback_blend_unit.sv
// Top level: PID controller blended with a moving-average feedback term.
// Step request: the result reaches m_tvalid after seven passes through one shared 17x34
//   multiplier; no new request is taken until the result is in the output register.
// Preload, clear and reserved requests are taken while idle and give no result.
// A finished result waits in the output register while the next request is taken.
// aresetn (synchronous, active low) zeroes gains, window, integral and history.
module pid_with_averaged_feedback_blend_unit import pidab_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [95:0]           s_tdata,   // error_sample, measured_sample, preset_output
    input  logic [FUNC_W-1:0]     s_tuser,   // func
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,   // drive_out
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cmd_t dp_cmd;
    sts_t dp_sts;

    // Controller: walks the multiplier schedule.
    //   PID term:   kp*err, kd*(err-prev), ki*integral low, ki*integral high
    //   a settle state so the PID sum is complete before it is reused
    //   blend:      (1-b)*pid low, (1-b)*pid high, b*feedback
    // When the new sample is nonzero, the window mean divider starts with the first
    // product and is done well before the feedback product; the controller still waits on it.
    pidab_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .m_tready (m_tready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    // Datapath: window with running sum, saturating integral, multiplier,
    // accumulators and output register.
    pidab_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_err    (signed'(s_tdata[DATA_W-1:0])),
        .in_meas   (signed'(s_tdata[2*DATA_W-1:DATA_W])),
        .in_preset (signed'(s_tdata[3*DATA_W-1:2*DATA_W])),
        .cmd       (dp_cmd),
        .sts       (dp_sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    // a finished result never overwrites one that is still stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |-> !(m_tvalid && !m_tready))
        else $error("result loaded over a stalled result");

    // feedback product only once the window mean is settled
    a_fb_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.mul_en && dp_cmd.op == OP_FB) |-> dp_sts.fb_ready)
        else $error("feedback product issued while divider busy");

    // multiplier stays quiet while requests are being taken
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !dp_cmd.mul_en)
        else $error("multiplier op issued while idle");

    // a step request, taken while no result waits, leads to a result load
    a_step_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.step_load && !m_tvalid) |-> ##10 dp_cmd.out_load)
        else $error("step request did not produce a result on schedule");

endmodule

>>> hw/rtl/pidab_div.sv
// Multi-cycle divider of the signed window sum by the window length, toward zero.
module pidab_div import pidab_pkg::*; #(
    parameter int SUM_W   = 35,
    parameter int DIVISOR = WINDOW_LEN_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    output logic                    busy,
    output logic [DATA_W-1:0]       quotient
);

    localparam int DIV_CYC = (SUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_W   = DIV_CYC * DIV_STEPS;
    localparam int REM_W   = $clog2(DIVISOR);
    localparam int CNT_W   = $clog2(DIV_CYC + 1);
    localparam logic [REM_W:0] TRIAL_D = (REM_W + 1)'(DIVISOR);

    logic [PAD_W-1:0]     dvd_reg, dvd_next, dvd_v;
    logic [PAD_W-1:0]     quo_reg, quo_next;
    logic [REM_W-1:0]     rem_reg, rem_next, rem_v;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [REM_W:0]       trial;
    logic [DIV_STEPS-1:0] qbits;
    logic [SUM_W-1:0]     mag;
    logic signed [DATA_W:0] q_mag, q_signed;

    assign mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

    // one restoring step per bit, DIV_STEPS bits per cycle on a narrow remainder
    always_comb begin
        rem_v = rem_reg;
        dvd_v = dvd_reg;
        qbits = '0;
        trial = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial = {rem_v, dvd_v[PAD_W-1]};
            dvd_v = dvd_v << 1;
            if (trial >= TRIAL_D) begin
                trial = trial - TRIAL_D;
                qbits[DIV_STEPS-1-i] = 1'b1;
            end
            rem_v = trial[REM_W-1:0];
        end
    end

    always_comb begin
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        if (start) begin
            dvd_next = PAD_W'(mag);
            quo_next = '0;
            rem_next = '0;
            cnt_next = CNT_W'(DIV_CYC);
            neg_next = dividend[SUM_W-1];
        end else if (cnt_reg != '0) begin
            dvd_next = dvd_v;
            quo_next = {quo_reg[PAD_W-DIV_STEPS-1:0], qbits};
            rem_next = rem_v;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign busy     = (cnt_reg != '0);
    assign q_mag    = signed'({1'b0, quo_reg[DATA_W-1:0]});
    assign q_signed = neg_reg ? -q_mag : q_mag;
    assign quotient = q_signed[DATA_W-1:0];

endmodule

>>> hw/rtl/pidab_dp.sv
// Datapath: controller state, measurement window, shared multiplier and output register.
module pidab_dp import pidab_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic signed [DATA_W-1:0] in_err,
    input  logic signed [DATA_W-1:0] in_meas,
    input  logic signed [DATA_W-1:0] in_preset,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic                     m_tready,
    output logic                     m_tvalid,
    output logic [DATA_W-1:0]        m_tdata
);

    localparam int SUM_W = DATA_W + $clog2(WINDOW_LEN);
    localparam int RES_W = ACC_W - FRAC_W;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0]  DATA_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0]  DATA_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

    // configuration
    logic signed [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic [BLEND_W-1:0]       bw_reg;

    // controller state
    logic signed [DATA_W-1:0]  win_reg [WINDOW_LEN];
    logic signed [DATA_W-1:0]  win_next [WINDOW_LEN];
    logic signed [SUM_W-1:0]   sum_reg, sum_next, sum_step;
    logic signed [DATA_W-1:0]  prev_err_reg, prev_err_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next, integ_sat;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [DATA_W-1:0]  last_out_reg, last_out_next;
    logic                      meas_nz_reg, meas_nz_next;

    // per-step operands
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W:0]   diff_reg;

    // multiplier and accumulators
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    op_t                       op_d_reg;
    logic                      mul_v_reg;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   pid_acc_reg, pid_acc_next;
    logic signed [ACC_W-1:0]   out_acc_reg, out_acc_next;
    logic signed [PID_W-1:0]   pid;
    logic signed [DATA_W-1:0]  fb;
    logic [BLEND_W-1:0]        b_eff, one_minus_b;

    // result
    logic signed [RES_W-1:0]   res_wide;
    logic                      res_ovf;
    logic signed [DATA_W-1:0]  res_sat;
    logic [DATA_W-1:0]         out_data_reg;
    logic                      out_valid_reg;

    // window mean
    logic                      div_busy;
    logic [DATA_W-1:0]         div_q;

    pidab_div #(
        .SUM_W   (SUM_W),
        .DIVISOR (WINDOW_LEN)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.fb_start && meas_nz_reg),
        .dividend (sum_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= '0;
            ki_reg <= '0;
            kd_reg <= '0;
            bw_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PROP_GAIN:    kp_reg <= signed'(cfg_wdata);
                CFG_INTEG_GAIN:   ki_reg <= signed'(cfg_wdata);
                CFG_DERIV_GAIN:   kd_reg <= signed'(cfg_wdata);
                CFG_BLEND_WEIGHT: bw_reg <= cfg_wdata[BLEND_W-1:0];
                default: ;
            endcase
        end
    end

    // running window sum: drop the oldest tap, add the new sample
    assign sum_step  = sum_reg - SUM_W'(win_reg[WINDOW_LEN-1]) + SUM_W'(in_meas);
    assign integ_sum = (INTEG_W + 1)'(integ_reg) + (INTEG_W + 1)'(in_err);

    always_comb begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
    end

    always_comb begin
        win_next      = win_reg;
        sum_next      = sum_reg;
        prev_err_next = prev_err_reg;
        integ_next    = integ_reg;
        last_out_next = last_out_reg;
        meas_nz_next  = meas_nz_reg;
        priority if (cmd.clear) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_next[i] = '0;
            end
            sum_next      = '0;
            prev_err_next = '0;
            integ_next    = '0;
            last_out_next = '0;
        end else if (cmd.preload) begin
            prev_err_next = in_err;
            last_out_next = in_preset;
            integ_next    = '0;
        end else if (cmd.step_load) begin
            for (int i = 1; i < WINDOW_LEN; i++) begin
                win_next[i] = win_reg[i-1];
            end
            win_next[0]   = in_meas;
            sum_next      = sum_step;
            prev_err_next = in_err;
            integ_next    = integ_sat;
            meas_nz_next  = (in_meas != '0);
        end else if (cmd.out_load) begin
            last_out_next = res_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_reg[i] <= '0;
            end
            sum_reg      <= '0;
            prev_err_reg <= '0;
            integ_reg    <= '0;
            last_out_reg <= '0;
            meas_nz_reg  <= 1'b0;
        end else begin
            win_reg      <= win_next;
            sum_reg      <= sum_next;
            prev_err_reg <= prev_err_next;
            integ_reg    <= integ_next;
            last_out_reg <= last_out_next;
            meas_nz_reg  <= meas_nz_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_load) begin
            err_reg  <= in_err;
            diff_reg <= (DATA_W + 1)'(in_err) - (DATA_W + 1)'(prev_err_reg);
        end
    end

    // operand select for the shared multiplier
    assign b_eff       = (bw_reg > BLEND_W'(BLEND_ONE)) ? BLEND_W'(BLEND_ONE) : bw_reg;
    assign one_minus_b = BLEND_W'(BLEND_ONE) - b_eff;
    assign pid         = pid_acc_reg[FRAC_W +: PID_W];
    assign fb          = meas_nz_reg ? signed'(div_q) : last_out_reg;

    always_comb begin
        unique case (cmd.op)
            OP_KP_ERR: begin
                mul_a = MUL_A_W'(kp_reg);
                mul_b = MUL_B_W'(err_reg);
            end
            OP_KD_DIFF: begin
                mul_a = MUL_A_W'(kd_reg);
                mul_b = MUL_B_W'(diff_reg);
            end
            OP_KI_LO: begin
                mul_a = MUL_A_W'(ki_reg);
                mul_b = signed'(MUL_B_W'(integ_reg[INTEG_SPLIT-1:0]));
            end
            OP_KI_HI: begin
                mul_a = MUL_A_W'(ki_reg);
                mul_b = MUL_B_W'(signed'(integ_reg[INTEG_W-1:INTEG_SPLIT]));
            end
            OP_PID_LO: begin
                mul_a = signed'(MUL_A_W'(one_minus_b));
                mul_b = signed'(MUL_B_W'(pid[PID_SPLIT-1:0]));
            end
            OP_PID_HI: begin
                mul_a = signed'(MUL_A_W'(one_minus_b));
                mul_b = MUL_B_W'(signed'(pid[PID_W-1:PID_SPLIT]));
            end
            OP_FB: begin
                mul_a = signed'(MUL_A_W'(b_eff));
                mul_b = MUL_B_W'(fb);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = ACC_W'(prod_reg);

    // accumulate the product registered in the previous cycle
    always_comb begin
        pid_acc_next = pid_acc_reg;
        out_acc_next = out_acc_reg;
        if (cmd.step_load) begin
            pid_acc_next = '0;
            out_acc_next = '0;
        end else if (mul_v_reg) begin
            unique case (op_d_reg)
                OP_KP_ERR, OP_KD_DIFF, OP_KI_LO: pid_acc_next = pid_acc_reg + prod_ext;
                OP_KI_HI:  pid_acc_next = pid_acc_reg + (prod_ext <<< INTEG_SPLIT);
                OP_PID_LO, OP_FB: out_acc_next = out_acc_reg + prod_ext;
                OP_PID_HI: out_acc_next = out_acc_reg + (prod_ext <<< PID_SPLIT);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg <= 1'b0;
        end else begin
            mul_v_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg    <= prod_next;
        op_d_reg    <= cmd.op;
        pid_acc_reg <= pid_acc_next;
        out_acc_reg <= out_acc_next;
    end

    // floor to Q16.16, then clamp to 32 bits
    assign res_wide = out_acc_reg[ACC_W-1:FRAC_W];
    assign res_ovf  = !((&res_wide[RES_W-1:DATA_W-1]) || !(|res_wide[RES_W-1:DATA_W-1]));

    always_comb begin
        if (res_ovf) begin
            res_sat = res_wide[RES_W-1] ? DATA_MIN : DATA_MAX;
        end else begin
            res_sat = res_wide[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= res_sat;
        end
    end

    assign sts.fb_ready = !div_busy;
    assign sts.out_full = out_valid_reg;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;

endmodule

>>> hw/rtl/pidab_ctrl.sv
// Controller: sequences the multiplier operations of one step request.
module pidab_ctrl import pidab_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [FUNC_W-1:0] s_func,
    input  logic              m_tready,
    input  sts_t              sts,
    output cmd_t              cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PID    = 7'b0000010,
        S_SETTLE = 7'b0000100,
        S_BLEND  = 7'b0001000,
        S_FBWAIT = 7'b0010000,
        S_FIN    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        cmd           = '0;
        cmd.op        = op_reg;
        cmd.step_load = accept && (s_func == FUNC_STEP);
        cmd.preload   = accept && (s_func == FUNC_PRELOAD);
        cmd.clear     = accept && (s_func == FUNC_CLEAR);
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.step_load) begin
                    state_next = S_PID;
                    op_next    = OP_KP_ERR;
                end
            end
            S_PID: begin
                cmd.mul_en   = 1'b1;
                cmd.fb_start = (op_reg == OP_KP_ERR);
                unique case (op_reg)
                    OP_KP_ERR:  op_next = OP_KD_DIFF;
                    OP_KD_DIFF: op_next = OP_KI_LO;
                    OP_KI_LO:   op_next = OP_KI_HI;
                    default:    state_next = S_SETTLE;
                endcase
            end
            S_SETTLE: begin
                state_next = S_BLEND;
                op_next    = OP_PID_LO;
            end
            S_BLEND: begin
                cmd.mul_en = 1'b1;
                if (op_reg == OP_PID_LO) begin
                    op_next = OP_PID_HI;
                end else begin
                    state_next = S_FBWAIT;
                end
            end
            S_FBWAIT: begin
                cmd.op = OP_FB;
                if (sts.fb_ready) begin
                    cmd.mul_en = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!sts.out_full || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_KP_ERR;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule
